@@ hdl/bgd_pkg.sv @@
// Shared types and constants for the button gesture debouncer.
// Used by bgd_core, bgd_evq and button_gesture_debouncer_top. No dependencies.
package bgd_pkg;

   // Event codes carried in the result word
   typedef enum logic [2:0] {
      EV_PRESS   = 3'd0,
      EV_RELEASE = 3'd1,
      EV_LONG    = 3'd2,
      EV_SINGLE  = 3'd3,
      EV_DOUBLE  = 3'd4
   } event_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_PRESS_LEVEL  = 3'd0;
   localparam logic [2:0] CSR_DEBOUNCE     = 3'd1;
   localparam logic [2:0] CSR_SHORT_PRESS  = 3'd2;
   localparam logic [2:0] CSR_LONG_PRESS   = 3'd3;
   localparam logic [2:0] CSR_TAP_WINDOW   = 3'd4;

   // Configuration reset values
   localparam logic        RST_PRESS_LEVEL  = 1'b0;
   localparam logic [15:0] RST_DEBOUNCE     = 16'd30;
   localparam logic [15:0] RST_SHORT_PRESS  = 16'd50;
   localparam logic [15:0] RST_LONG_PRESS   = 16'd800;
   localparam logic [15:0] RST_TAP_WINDOW   = 16'd200;

   localparam int unsigned MAX_EVENTS = 3;

   // Configuration seen by the gesture logic
   typedef struct packed {
      logic        press_level;
      logic [15:0] debounce_time;
      logic [15:0] short_press_time;
      logic [15:0] long_press_time;
      logic [15:0] double_tap_window;
   } cfg_type;

   // Events produced by one poll, in emission order
   typedef struct packed {
      logic [1:0] cnt;
      event_type  ev0;
      event_type  ev1;
      event_type  ev2;
   } ev_bundle_type;

endpackage

@@ hdl/bgd_core.sv @@
// Gesture state and per-poll event decision for the button gesture debouncer.
// Depends on bgd_pkg.
module bgd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  bgd_pkg::cfg_type       cfg,
   input  logic                   take,         // poll consumed this cycle
   input  logic                   pin_level,
   input  logic [31:0]            now_ms,
   output bgd_pkg::ev_bundle_type events
);

   logic        raw_prev_ff, raw_prev_in;
   logic [31:0] last_change_ff, last_change_in;
   logic        deb_pressed_ff, deb_pressed_in;
   logic [31:0] press_start_ff, press_start_in;
   logic [31:0] release_start_ff, release_start_in;
   logic [1:0]  tap_count_ff, tap_count_in;
   logic        long_rep_ff, long_rep_in;

   logic        pressed, changed, accept_chg, press_ev, rel_ev;
   logic        click, long_ev, tap_expire, single_ev, double_ev;
   logic [31:0] since_change, held, since_release;
   logic [1:0]  n;
   bgd_pkg::event_type slot [3];

   // Debounce and hold timing
   always_comb begin
      pressed       = (pin_level == cfg.press_level);
      changed       = (pressed != raw_prev_ff);
      since_change  = now_ms - last_change_ff;
      held          = now_ms - press_start_ff;
      since_release = now_ms - release_start_ff;
      // a raw change restarts the timer, so the elapsed time is zero then
      accept_chg = !changed && (since_change > {16'd0, cfg.debounce_time})
                   && (pressed != deb_pressed_ff);
      press_ev   = accept_chg && pressed;
      rel_ev     = accept_chg && !pressed;
      click      = (held < {16'd0, cfg.long_press_time})
                   && (held >= {16'd0, cfg.short_press_time});
      // a fresh press fires long only when the long time is zero
      if (press_ev) begin
         long_ev = (cfg.long_press_time == 16'd0);
      end else begin
         long_ev = !rel_ev && deb_pressed_ff && !long_rep_ff
                   && (held >= {16'd0, cfg.long_press_time});
      end
      // a release this poll restarts the tap window
      tap_expire = !rel_ev && (tap_count_ff != 2'd0)
                   && (since_release > {16'd0, cfg.double_tap_window});
      single_ev  = tap_expire && (tap_count_ff == 2'd1);
      double_ev  = tap_expire && (tap_count_ff == 2'd2);
   end

   // Pack events in order
   always_comb begin
      n       = 2'd0;
      slot[0] = bgd_pkg::EV_PRESS;
      slot[1] = bgd_pkg::EV_PRESS;
      slot[2] = bgd_pkg::EV_PRESS;
      if (accept_chg) begin
         slot[n] = press_ev ? bgd_pkg::EV_PRESS : bgd_pkg::EV_RELEASE;
         n       = n + 2'd1;
      end
      if (long_ev) begin
         slot[n] = bgd_pkg::EV_LONG;
         n       = n + 2'd1;
      end
      if (single_ev || double_ev) begin
         slot[n] = single_ev ? bgd_pkg::EV_SINGLE : bgd_pkg::EV_DOUBLE;
         n       = n + 2'd1;
      end
      events.cnt = n;
      events.ev0 = slot[0];
      events.ev1 = slot[1];
      events.ev2 = slot[2];
   end

   // Next state
   always_comb begin
      raw_prev_in      = raw_prev_ff;
      last_change_in   = last_change_ff;
      deb_pressed_in   = deb_pressed_ff;
      press_start_in   = press_start_ff;
      release_start_in = release_start_ff;
      tap_count_in     = tap_count_ff;
      long_rep_in      = long_rep_ff;
      if (take) begin
         if (changed) begin
            raw_prev_in    = pressed;
            last_change_in = now_ms;
         end
         if (accept_chg) begin
            deb_pressed_in = pressed;
         end
         if (press_ev) begin
            press_start_in = now_ms;
            long_rep_in    = 1'b0;
         end
         if (long_ev) begin
            long_rep_in = 1'b1;
         end
         if (rel_ev) begin
            release_start_in = now_ms;
            if (click && (tap_count_ff != 2'd3)) begin
               tap_count_in = tap_count_ff + 2'd1;
            end
         end else if (tap_expire) begin
            tap_count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff    <= 1'b0;
         last_change_ff <= 32'd0;
         deb_pressed_ff <= 1'b0;
         press_start_ff <= 32'd0;
         tap_count_ff   <= 2'd0;
         long_rep_ff    <= 1'b0;
      end else begin
         raw_prev_ff    <= raw_prev_in;
         last_change_ff <= last_change_in;
         deb_pressed_ff <= deb_pressed_in;
         press_start_ff <= press_start_in;
         tap_count_ff   <= tap_count_in;
         long_rep_ff    <= long_rep_in;
      end
   end

   // release time is only read while a tap is pending
   always_ff @(posedge clock) begin
      release_start_ff <= release_start_in;
   end

   // A release and a tap decision never come from the same poll
   a_no_tap_on_release: assert property (@(posedge clock) disable iff (reset)
      rel_ev |-> !(single_ev || double_ev))
      else $error("tap event in the poll that released");

   // After a press the long flag is set only if the long time is zero
   a_press_long_flag: assert property (@(posedge clock) disable iff (reset)
      (take && press_ev) |=> (long_rep_ff == (cfg.long_press_time == 16'd0)))
      else $error("long flag wrong after press");

   // A pending tap implies the button is or was released
   a_tap_needs_release: assert property (@(posedge clock) disable iff (reset)
      (tap_count_ff != 2'd0 && deb_pressed_ff) |-> $past(tap_count_ff != 2'd0)
         || !$past(deb_pressed_ff))
      else $error("tap counted while held");

endmodule

@@ hdl/bgd_evq.sv @@
// Event queue: takes up to three event words per poll, drains one per cycle
// while out_ready is high. Depends on bgd_pkg.
module bgd_evq #(
   parameter int unsigned DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bgd_pkg::ev_bundle_type events,
   output logic                   room,        // space for a full poll's words
   output logic                   out_valid,
   input  logic                   out_ready,
   output bgd_pkg::event_type     out_event,
   output logic                   out_last
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - bgd_pkg::MAX_EVENTS);
   localparam logic [PTR_W:0]   DEPTH_W    = (PTR_W + 1)'(DEPTH);

   bgd_pkg::event_type mem_ev_ff   [DEPTH];
   logic               mem_last_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         push_cnt;
   logic               pop;
   bgd_pkg::event_type in_ev [3];
   logic [PTR_W-1:0]   wr_idx [3];

   // Pointer plus a small offset, wrapped at the depth
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [1:0] k);
      logic [PTR_W:0] s;
      s = {1'b0, p} + (PTR_W + 1)'(k);
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[PTR_W-1:0];
   endfunction

   always_comb begin
      in_ev[0]  = events.ev0;
      in_ev[1]  = events.ev1;
      in_ev[2]  = events.ev2;
      push_cnt  = push ? events.cnt : 2'd0;
      pop       = out_valid && out_ready;
      for (int i = 0; i < 3; i++) begin
         wr_idx[i] = ptr_add(wr_ptr_ff, 2'(i));
      end
      wr_ptr_in = ptr_add(wr_ptr_ff, push_cnt);
      rd_ptr_in = pop ? ptr_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   assign room      = (count_ff <= ROOM_LIMIT);
   assign out_valid = (count_ff != '0);
   assign out_event = mem_ev_ff[rd_ptr_ff];
   assign out_last  = mem_last_ff[rd_ptr_ff];

   // Storage writes
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_cnt) begin
            mem_ev_ff[wr_idx[i]]   <= in_ev[i];
            mem_last_ff[wr_idx[i]] <= (2'(i) == push_cnt - 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("event queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> room)
      else $error("push without room");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push_cnt == 2'd0 && !pop) |=> $stable(count_ff))
      else $error("count moved while idle");

endmodule

@@ hdl/button_gesture_debouncer_top.sv @@
// Top level of the button gesture debouncer: poll input register, configuration
// registers, gesture core and event queue. Depends on bgd_pkg, bgd_core, bgd_evq.

// Each poll word (pin level, millisecond timestamp) is taken into an input
// register and decided by the gesture core once the queue has room; the 0 to 3
// event words it causes (press/release, long press, single/double tap, in that
// order, the last one flagged by rsp_tlast) enter the event queue and appear on
// the result side from the cycle after that, one word per cycle while rsp_tready
// is high. A poll can be accepted every cycle; the only stall comes from the
// event queue, which takes a poll only while it has room for three words
// (QUEUE_DEPTH entries), so a sustained stream of polls that each cause several
// events is limited to one event word per cycle by the result port. The user
// writes configuration only while no poll is in flight; it is not enforced.
module button_gesture_debouncer_top #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // poll input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [0] pin_level, [32:1] now_ms, rest zero
   // event output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] event_res, rest zero
   output logic        rsp_tlast,   // last_of_run
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   bgd_pkg::cfg_type       cfg_ff, cfg_in;
   bgd_pkg::ev_bundle_type events;
   bgd_pkg::event_type     out_event;
   logic                   poll_valid_ff, poll_valid_in;
   logic                   poll_level_ff;
   logic [31:0]            poll_now_ff;
   logic                   room, take, req_take;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bgd_pkg::CSR_PRESS_LEVEL:  cfg_in.press_level       = csr_wdata[0];
            bgd_pkg::CSR_DEBOUNCE:     cfg_in.debounce_time     = csr_wdata;
            bgd_pkg::CSR_SHORT_PRESS:  cfg_in.short_press_time  = csr_wdata;
            bgd_pkg::CSR_LONG_PRESS:   cfg_in.long_press_time   = csr_wdata;
            bgd_pkg::CSR_TAP_WINDOW:   cfg_in.double_tap_window = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_level       <= bgd_pkg::RST_PRESS_LEVEL;
         cfg_ff.debounce_time     <= bgd_pkg::RST_DEBOUNCE;
         cfg_ff.short_press_time  <= bgd_pkg::RST_SHORT_PRESS;
         cfg_ff.long_press_time   <= bgd_pkg::RST_LONG_PRESS;
         cfg_ff.double_tap_window <= bgd_pkg::RST_TAP_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Poll input register; refilled in the cycle the core consumes it
   assign take       = poll_valid_ff && room;
   assign req_tready = !poll_valid_ff || take;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      poll_valid_in = poll_valid_ff;
      if (req_take) begin
         poll_valid_in = 1'b1;
      end else if (take) begin
         poll_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         poll_level_ff <= req_tdata[0];
         poll_now_ff   <= req_tdata[32:1];
      end
   end

   bgd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .take      (take),
      .pin_level (poll_level_ff),
      .now_ms    (poll_now_ff),
      .events    (events)
   );

   bgd_evq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .events    (events),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_event (out_event),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, out_event};

endmodule

@@ verif/tb_button_gesture_debouncer_top.sv @@
`timescale 1ns / 1ps
// Testbench for button_gesture_debouncer_top: directed gestures, then randomized
// press/release sequences under changing settings, checked word by word against
// a built-in gesture tracker. Depends on bgd_pkg and the top level RTL.
module tb_button_gesture_debouncer_top;

   // first register index the block does not decode
   localparam logic [2:0]  CSR_FIRST_UNUSED = 3'd5;
   localparam int unsigned RANDOM_POLLS     = 330;

   typedef struct {
      bgd_pkg::event_type ev;
      bit                 last;
   } gesture_word_type;

   // Tracks the gesture state, predicts event words per poll and checks them
   class gesture_tracker_type;
      bit               act_level;
      bit [15:0]        deb_ms, short_ms, long_ms, win_ms;
      bit               raw_prev;
      bit [31:0]        change_ts;
      bit               deb_pressed;
      bit [31:0]        press_ts;
      bit [31:0]        release_ts;
      bit [1:0]         taps;
      bit               long_done;
      gesture_word_type due_words[$];
      int unsigned      errors, polls, words, writes;
      int unsigned      ev_seen[5];

      function new();
         act_level   = bgd_pkg::RST_PRESS_LEVEL;
         deb_ms      = bgd_pkg::RST_DEBOUNCE;
         short_ms    = bgd_pkg::RST_SHORT_PRESS;
         long_ms     = bgd_pkg::RST_LONG_PRESS;
         win_ms      = bgd_pkg::RST_TAP_WINDOW;
         raw_prev    = 1'b0;
         change_ts   = '0;
         deb_pressed = 1'b0;
         press_ts    = '0;
         release_ts  = '0;
         taps        = '0;
         long_done   = 1'b0;
         errors      = 0;
         polls       = 0;
         words       = 0;
         writes      = 0;
         foreach (ev_seen[i]) ev_seen[i] = 0;
      endfunction

      function void write_reg(bit [2:0] idx, bit [15:0] value);
         writes++;
         case (idx)
            bgd_pkg::CSR_PRESS_LEVEL: act_level = value[0];
            bgd_pkg::CSR_DEBOUNCE:    deb_ms    = value;
            bgd_pkg::CSR_SHORT_PRESS: short_ms  = value;
            bgd_pkg::CSR_LONG_PRESS:  long_ms   = value;
            bgd_pkg::CSR_TAP_WINDOW:  win_ms    = value;
            default: ;
         endcase
      endfunction

      // One accepted poll: update state, queue the event words it causes
      function void note_poll(bit level, bit [31:0] now_ms);
         bit                 pressed;
         bit [31:0]          since;
         bit [31:0]          held;
         bgd_pkg::event_type evs[$];
         polls++;
         pressed = (level == act_level);
         if (pressed != raw_prev) begin
            change_ts = now_ms;
            raw_prev  = pressed;
         end
         // debounced press or release
         since = now_ms - change_ts;
         if (since > deb_ms && pressed != deb_pressed) begin
            deb_pressed = pressed;
            if (pressed) begin
               press_ts  = now_ms;
               long_done = 1'b0;
               evs.push_back(bgd_pkg::EV_PRESS);
            end else begin
               release_ts = now_ms;
               evs.push_back(bgd_pkg::EV_RELEASE);
               held = release_ts - press_ts;
               if (held < long_ms && held >= short_ms && taps != 2'd3)
                  taps++;
            end
         end
         // long press, once per hold
         since = now_ms - press_ts;
         if (deb_pressed && !long_done && since >= long_ms) begin
            long_done = 1'b1;
            evs.push_back(bgd_pkg::EV_LONG);
         end
         // tap decision after the window; three or more clicks are dropped
         since = now_ms - release_ts;
         if (taps != 2'd0 && since > win_ms) begin
            if (taps == 2'd1)
               evs.push_back(bgd_pkg::EV_SINGLE);
            else if (taps == 2'd2)
               evs.push_back(bgd_pkg::EV_DOUBLE);
            taps = 2'd0;
         end
         foreach (evs[i])
            due_words.push_back('{ev: evs[i], last: (i == evs.size() - 1)});
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_event(logic [7:0] data, logic last);
         gesture_word_type want;
         if (due_words.size() == 0) begin
            report_mismatch($sformatf("event word %0d arrived with none pending",
                                      data[2:0]));
            return;
         end
         want = due_words.pop_front();
         words++;
         ev_seen[want.ev]++;
         if (data[2:0] !== want.ev)
            report_mismatch($sformatf("word %0d: event %0d, wanted %s",
                                      words, data[2:0], want.ev.name()));
         if (last !== want.last)
            report_mismatch($sformatf("word %0d: tlast %b, wanted %b",
                                      words, last, want.last));
      endtask

      function int unsigned outstanding();
         return due_words.size();
      endfunction

      task close_out();
         if (due_words.size() != 0)
            report_mismatch($sformatf("%0d event words never arrived", due_words.size()));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [0] pin_level, [32:1] now_ms, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [2:0] event_res, rest zero
   logic        rsp_tlast;   // last_of_run
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   gesture_tracker_type tracker;

   // stimulus knobs and the settings the stimulus is shaped by
   int unsigned req_gap_pct;
   int unsigned rsp_stall_pct;
   bit          cur_active;
   int unsigned cur_deb, cur_short, cur_long, cur_win;
   bit [31:0]   t_now;
   int unsigned items_sent;
   int unsigned settings_used;

   button_gesture_debouncer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample handshakes and register writes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we === 1'b1) tracker.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready === 1'b1)
            tracker.note_poll(req_tdata[0], req_tdata[32:1]);
         if (rsp_tvalid === 1'b1 && rsp_tready)
            tracker.check_event(rsp_tdata, rsp_tlast);
      end
   end

   // Result-side backpressure in bursts
   initial begin : rsp_pacer
      int unsigned stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Present one poll word, hold it until accepted; entered and left at a falling edge
   task automatic send_poll(bit level, bit [31:0] now_ms);
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, now_ms, level};
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
      @(negedge clock);
   endtask

   // Poll with the button pressed or not, dt ms after the previous poll
   task automatic poll_state(bit pressed, int unsigned dt);
      t_now += dt;
      send_poll(pressed ? cur_active : ~cur_active, t_now);
   endtask

   task automatic write_reg(bit [2:0] idx, bit [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         bgd_pkg::CSR_PRESS_LEVEL: cur_active = value[0];
         bgd_pkg::CSR_DEBOUNCE:    cur_deb    = 32'(value);
         bgd_pkg::CSR_SHORT_PRESS: cur_short  = 32'(value);
         bgd_pkg::CSR_LONG_PRESS:  cur_long   = 32'(value);
         bgd_pkg::CSR_TAP_WINDOW:  cur_win    = 32'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Stop sending, let every pending word out, then cover the pipeline latency
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Contact bounce: quick alternating polls ending on the opposite level
   task automatic bounce(bit toward);
      int unsigned n;
      n = $urandom_range(0, 3);
      repeat (n) begin
         poll_state(toward, $urandom_range(0, 2));
         poll_state(~toward, $urandom_range(0, 2));
      end
   endtask

   // Keep a level for about dur ms in a handful of polls
   task automatic hold_level(bit pressed, int unsigned dur);
      int unsigned step, spent, dt;
      step  = dur / $urandom_range(2, 5) + 1;
      spent = 0;
      poll_state(pressed, $urandom_range(0, 3));
      while (spent <= dur) begin
         dt = $urandom_range(step / 2 + 1, step);
         poll_state(pressed, dt);
         spent += dt;
      end
   endtask

   // One press and release, timed around the current thresholds
   task automatic run_gesture();
      int unsigned hold, gap, span, kind;
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
         span = (cur_long > cur_short) ? cur_long - cur_short - 1 : 0;
         hold = cur_short + $urandom_range(0, span);
      end else if (kind == 1) begin
         hold = cur_long + $urandom_range(1, 40);
      end else if (kind == 2) begin
         hold = $urandom_range(0, cur_short);
      end else begin
         hold = $urandom_range(0, cur_long + cur_short + 10);
      end
      if ($urandom_range(0, 1) == 1)
         gap = $urandom_range(0, cur_win / 2);
      else
         gap = cur_win + $urandom_range(1, 40);
      bounce(1'b1);
      hold_level(1'b1, cur_deb + hold);
      bounce(1'b0);
      hold_level(1'b0, cur_deb + gap);
   endtask

   // Random levels and time jumps, including backward ones
   task automatic line_noise();
      repeat ($urandom_range(2, 6)) begin
         if ($urandom_range(0, 3) == 0)
            t_now = $urandom;
         else
            t_now += $urandom_range(0, 5);
         send_poll(1'($urandom_range(0, 1)), t_now);
      end
   endtask

   // Choose and write a full register set; the first two sets are the extremes
   task automatic pick_settings();
      bit [15:0]   deb, shrt, lng, win;
      int unsigned profile;
      if (settings_used == 0)
         profile = 6;
      else if (settings_used == 1)
         profile = 7;
      else
         profile = $urandom_range(0, 5);
      deb  = 16'($urandom_range(0, 4));
      shrt = 16'($urandom_range(2, 15));
      lng  = 16'($urandom_range(20, 60));
      win  = 16'($urandom_range(5, 30));
      case (profile)
         1: begin
            deb  = bgd_pkg::RST_DEBOUNCE;
            shrt = bgd_pkg::RST_SHORT_PRESS;
            lng  = bgd_pkg::RST_LONG_PRESS;
            win  = bgd_pkg::RST_TAP_WINDOW;
         end
         2: begin
            deb  = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom_range(0, 16'hFFFF));
            shrt = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF));
            lng  = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF));
            win  = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom_range(0, 16'hFFFF));
         end
         3: begin
            deb  = 16'($urandom_range(0, 16'hFFFF));
            shrt = 16'($urandom_range(0, 16'hFFFF));
            lng  = 16'($urandom_range(0, 16'hFFFF));
            win  = 16'($urandom_range(0, 16'hFFFF));
         end
         4: begin
            // short at or above long: no click can count
            lng  = 16'($urandom_range(0, 40));
            shrt = lng + 16'($urandom_range(0, 20));
         end
         5: lng = 16'd0;
         6: begin
            deb  = 16'hFFFF;
            shrt = 16'hFFFF;
            lng  = 16'hFFFF;
            win  = 16'hFFFF;
         end
         7: begin
            deb  = 16'h0;
            shrt = 16'h0;
            lng  = 16'h0;
            win  = 16'h0;
         end
         default: ;
      endcase
      settings_used++;
      write_reg(bgd_pkg::CSR_PRESS_LEVEL, 16'($urandom_range(0, 16'hFFFF)));
      write_reg(bgd_pkg::CSR_DEBOUNCE, deb);
      write_reg(bgd_pkg::CSR_SHORT_PRESS, shrt);
      write_reg(bgd_pkg::CSR_LONG_PRESS, lng);
      write_reg(bgd_pkg::CSR_TAP_WINDOW, win);
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_FIRST_UNUSED + 3'($urandom_range(0, 2)),
                   16'($urandom_range(0, 16'hFFFF)));
   endtask

   // Main sequence: reset, directed gestures, randomized phases, drain and verdict
   initial begin : main_seq
      int unsigned stop_at, phase_end, k;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      items_sent    = 0;
      settings_used = 0;
      t_now         = '0;
      cur_active    = bgd_pkg::RST_PRESS_LEVEL;
      cur_deb       = 32'(bgd_pkg::RST_DEBOUNCE);
      cur_short     = 32'(bgd_pkg::RST_SHORT_PRESS);
      cur_long      = 32'(bgd_pkg::RST_LONG_PRESS);
      cur_win       = 32'(bgd_pkg::RST_TAP_WINDOW);
      tracker       = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: press exactly at the debounce bound, two clicks, double tap
      // one ms past the window
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      t_now = '0;
      poll_state(1'b0, 0);
      poll_state(1'b1, 10);
      poll_state(1'b1, 30);
      poll_state(1'b1, 1);
      poll_state(1'b0, 50);
      poll_state(1'b0, 31);
      poll_state(1'b1, 8);
      poll_state(1'b1, 31);
      poll_state(1'b0, 59);
      poll_state(1'b0, 31);
      poll_state(1'b0, 200);
      poll_state(1'b0, 1);

      // Active high, no debounce: four fast clicks saturate the count, the window
      // then expires silently; one more click is left pending. Time wraps here.
      wait_idle();
      write_reg(bgd_pkg::CSR_PRESS_LEVEL, 16'hFFFF);
      write_reg(bgd_pkg::CSR_DEBOUNCE, 16'd0);
      write_reg(bgd_pkg::CSR_SHORT_PRESS, 16'd0);
      write_reg(bgd_pkg::CSR_LONG_PRESS, 16'hFFFF);
      write_reg(bgd_pkg::CSR_TAP_WINDOW, 16'd3);
      write_reg(CSR_FIRST_UNUSED + 3'd2, 16'h0001);
      t_now = 32'hFFFF_FFF8;
      for (k = 0; k < 5; k++) begin
         if (k == 4) poll_state(1'b0, 10);
         poll_state(1'b1, 1);
         poll_state(1'b1, 1);
         poll_state(1'b0, 1);
         poll_state(1'b0, 1);
      end

      // Zero long time: press, long press and the pending single tap in one poll;
      // then a release with crossed thresholds counts no click
      wait_idle();
      write_reg(bgd_pkg::CSR_LONG_PRESS, 16'd0);
      poll_state(1'b1, 1);
      poll_state(1'b1, 3);
      poll_state(1'b0, 1);
      poll_state(1'b0, 1);
      poll_state(1'b0, 10);

      // Randomized phases, each under a fresh register set
      stop_at = items_sent + RANDOM_POLLS;
      while (items_sent < stop_at) begin
         wait_idle();
         if (stop_at - items_sent < 80) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = 15 * $urandom_range(0, 2);
            rsp_stall_pct = 15 * $urandom_range(0, 2);
         end
         pick_settings();
         t_now     = $urandom;
         phase_end = items_sent + $urandom_range(30, 60);
         while (items_sent < phase_end && items_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0)
               line_noise();
            else
               run_gesture();
         end
      end

      wait_idle();
      tracker.close_out();
      $display("Run covered %0d polls, %0d event words: %0d press, %0d release,",
               tracker.polls, tracker.words, tracker.ev_seen[bgd_pkg::EV_PRESS],
               tracker.ev_seen[bgd_pkg::EV_RELEASE]);
      $display("%0d long, %0d single, %0d double, over %0d random register sets, %0d writes",
               tracker.ev_seen[bgd_pkg::EV_LONG], tracker.ev_seen[bgd_pkg::EV_SINGLE],
               tracker.ev_seen[bgd_pkg::EV_DOUBLE], settings_used, tracker.writes);
      if (tracker.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
